// ===== src/sac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the set-associative cache timing block.
// ----------------------------------------------------------------------------
package sac_pkg;

    // Default geometry
    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 32;

    // Timing rules
    localparam int MISS_BYTE_CYC = 25;
    localparam int WT_CYC        = 100;
    localparam int OB_MAX        = 10;

    // Stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 280;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAYS_IN_USE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_ALLOC   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_THROUGH = 3'd4;

    // Way indexes in the scan result are sized for the largest supported set
    localparam int SCAN_IDX_W = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic                  has_inv;
        logic [SCAN_IDX_W-1:0] hit_way;
        logic [SCAN_IDX_W-1:0] inv_way;
        logic [SCAN_IDX_W-1:0] old_way;
    } t_scan_res;

endpackage

// ===== src/sac_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_store
// Per-set row memories for tags and for valid, dirty and age state.
// ----------------------------------------------------------------------------
module sac_store #(
    parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF,
    parameter int SET_W      = 1,
    parameter int AGE_W      = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [SET_W-1:0]                     i_rd_set,
    input  logic                                 i_wr_en,
    input  logic [SET_W-1:0]                     i_wr_set,
    input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  i_wr_tags,
    input  logic [MAX_WAYS-1:0]                  i_wr_vld,
    input  logic [MAX_WAYS-1:0]                  i_wr_dirty,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]       i_wr_age,
    output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  o_rd_tags,
    output logic [MAX_WAYS-1:0]                  o_rd_vld,
    output logic [MAX_WAYS-1:0]                  o_rd_dirty,
    output logic [MAX_WAYS-1:0][AGE_W-1:0]       o_rd_age
);

    localparam int ST_ROW_W = MAX_WAYS * (2 + AGE_W);

    logic [MAX_WAYS*ADDR_WIDTH-1:0] r_tag_mem [MAX_SETS];
    logic [ST_ROW_W-1:0]            r_st_mem  [MAX_SETS];
    logic [MAX_SETS-1:0]            r_row_vld;
    logic [MAX_WAYS*ADDR_WIDTH-1:0] r_tag_q;
    logic [ST_ROW_W-1:0]            r_st_q;
    logic                           r_row_q;

    // Row memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set] <= i_wr_tags;
            r_st_mem[i_wr_set]  <= {i_wr_age, i_wr_dirty, i_wr_vld};
        end
        if (i_rd_en) begin
            r_tag_q <= r_tag_mem[i_rd_set];
            r_st_q  <= r_st_mem[i_rd_set];
        end
    end

    // One flag per set: a row never written reads with valid, dirty and age state all clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_row_q   <= 1'b0;
        end else begin
            if (i_wr_en) r_row_vld[i_wr_set] <= 1'b1;
            if (i_rd_en) r_row_q <= r_row_vld[i_rd_set];
        end
    end

    assign o_rd_tags = r_tag_q;
    assign {o_rd_age, o_rd_dirty, o_rd_vld} = r_row_q ? r_st_q : '0;

endmodule

// ===== src/sac_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_scan
// Shared tag compare unit that walks the ways of one set, one per cycle while i_run is high.
// ----------------------------------------------------------------------------
module sac_scan #(
    parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF,
    parameter int WAY_W      = 1,
    parameter int AGE_W      = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_run,
    input  logic [WAY_W-1:0]                    i_last_way,
    input  logic [ADDR_WIDTH-1:0]               i_tag,
    input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] i_tags,
    input  logic [MAX_WAYS-1:0]                 i_vld,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]      i_age,
    output logic                                o_done,
    output sac_pkg::t_scan_res                  o_res
);

    logic [WAY_W-1:0] r_w;
    logic             r_hit;
    logic             r_has_inv;
    logic [WAY_W-1:0] r_hw;
    logic [WAY_W-1:0] r_inv;
    logic [WAY_W-1:0] r_old;
    logic [AGE_W-1:0] r_old_age;
    logic             cur_hit;

    assign cur_hit = i_vld[r_w] && (i_tags[r_w] == i_tag);
    assign o_done  = i_run && (cur_hit || (r_w == i_last_way));

    // Walk the ways: first hit, lowest invalid way, oldest way (lowest on a tie).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= '0;
            r_hit     <= 1'b0;
            r_has_inv <= 1'b0;
            r_hw      <= '0;
            r_inv     <= '0;
            r_old     <= '0;
            r_old_age <= '0;
        end else if (i_start) begin
            r_w       <= '0;
            r_hit     <= 1'b0;
            r_has_inv <= 1'b0;
            r_hw      <= '0;
            r_inv     <= '0;
            r_old     <= '0;
            r_old_age <= '0;
        end else if (i_run) begin
            r_w <= r_w + 1'b1;
            if (cur_hit && !r_hit) begin
                r_hit <= 1'b1;
                r_hw  <= r_w;
            end
            if (!i_vld[r_w] && !r_has_inv) begin
                r_has_inv <= 1'b1;
                r_inv     <= r_w;
            end
            // Way 0 always seeds the oldest candidate with its own age.
            if (r_w == '0 || i_age[r_w] > r_old_age) begin
                r_old     <= r_w;
                r_old_age <= i_age[r_w];
            end
        end
    end

    always_comb begin
        o_res         = '0;
        o_res.hit     = r_hit;
        o_res.has_inv = r_has_inv;
        o_res.hit_way = sac_pkg::SCAN_IDX_W'(r_hw);
        o_res.inv_way = sac_pkg::SCAN_IDX_W'(r_inv);
        o_res.old_way = sac_pkg::SCAN_IDX_W'(r_old);
    end

endmodule

// ===== src/set_assoc_cache_lru_timing_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_timing_top
// Set-associative cache timing model with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// One access is handled at a time. It passes from acceptance through the set
// row read and the tag compare, which covers n ways: up to and including the
// hitting way on a hit, all ways in use on a miss. The single tag compare unit
// examines one way per cycle. The row update then writes the result register.
// The input is ready again in the cycle after the update; a waiting result
// holds the row update back.
// The result register lets the next access be taken while a result waits.
// Valid, dirty and age state is cleared at reset by one flag per set, so no
// clearing pass is needed.
module set_assoc_cache_lru_timing_top #(
    parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [sac_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [3:0]                         i_cfg_wdata,
    // Access stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // address [31:0], opcode [32], zero [39:33]
    input  logic [sac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit [0], dirty_eviction [1], access_cycles [17:2], total_loads [49:18],
    // total_stores [81:50], load_hits [113:82], load_misses [145:114],
    // store_hits [177:146], store_misses [209:178], total_cycles [273:210],
    // zero [279:274]
    output logic [sac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
    localparam int AGE_W   = WAY_W;
    localparam int IB_CAP  = $clog2(MAX_SETS + 1) - 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
    localparam logic [31:0] ADDR_MASK = 32'((33'd1 << ADDR_WIDTH) - 33'd1);

    // Configuration registers
    logic [3:0] r_index_bits;
    logic [3:0] r_offset_bits;
    logic [3:0] r_ways;
    logic       r_wa;
    logic       r_wt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= 4'd0;
            r_offset_bits <= 4'd2;
            r_ways        <= 4'd1;
            r_wa          <= 1'b1;
            r_wt          <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                sac_pkg::CFG_INDEX_BITS:    r_index_bits  <= i_cfg_wdata;
                sac_pkg::CFG_OFFSET_BITS:   r_offset_bits <= i_cfg_wdata;
                sac_pkg::CFG_WAYS_IN_USE:   r_ways        <= i_cfg_wdata;
                sac_pkg::CFG_WRITE_ALLOC:   r_wa          <= i_cfg_wdata[0];
                sac_pkg::CFG_WRITE_THROUGH: r_wt          <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Effective geometry after clamping
    logic [3:0]        ib;
    logic [3:0]        ob;
    logic [WAYS_W-1:0] ways;
    logic [WAY_W-1:0]  last_way;

    assign ib = (r_index_bits > 4'(IB_CAP)) ? 4'(IB_CAP) : r_index_bits;
    assign ob = (r_offset_bits > 4'(sac_pkg::OB_MAX)) ? 4'(sac_pkg::OB_MAX) : r_offset_bits;
    always_comb begin
        if (r_ways == 4'd0) begin
            ways = WAYS_W'(1);
        end else if ({1'b0, r_ways} > 5'(MAX_WAYS)) begin
            ways = WAYS_W'(MAX_WAYS);
        end else begin
            ways = WAYS_W'(r_ways);
        end
    end
    assign last_way = WAY_W'(ways - 1'b1);

    // Sequencer and access registers
    sac_pkg::t_state        r_state, n_state;
    logic [SET_W-1:0]       r_set;
    logic [ADDR_WIDTH-1:0]  r_tag;
    logic                   r_store;
    logic                   in_acc;
    logic                   upd_go;
    logic                   scan_done;
    sac_pkg::t_scan_res     scan_res;
    logic [31:0]            addr_m;
    logic [4:0]             tag_sh;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign addr_m = s_axis_tdata[31:0] & ADDR_MASK;
    assign tag_sh = {1'b0, ob} + {1'b0, ib};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        upd_go        = 1'b0;
        case (r_state)
            sac_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = sac_pkg::ST_READ;
            end
            sac_pkg::ST_READ: begin
                n_state = sac_pkg::ST_SCAN;
            end
            sac_pkg::ST_SCAN: begin
                if (scan_done) n_state = sac_pkg::ST_UPDATE;
            end
            sac_pkg::ST_UPDATE: begin
                upd_go = !m_axis_tvalid || m_axis_tready;
                if (upd_go) n_state = sac_pkg::ST_IDLE;
            end
            default: n_state = sac_pkg::ST_IDLE;
        endcase
    end

    // Split the address on acceptance.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set   <= SET_W'((addr_m >> ob) & ((32'd1 << ib) - 32'd1));
            r_tag   <= ADDR_WIDTH'(addr_m >> tag_sh);
            r_store <= s_axis_tdata[32];
        end
    end

    // Set row storage
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags, wr_tags;
    logic [MAX_WAYS-1:0]                 rd_vld, rd_dirty, wr_vld, wr_dirty;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age, wr_age;
    logic                                row_we;

    sac_store #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .SET_W      (SET_W),
        .AGE_W      (AGE_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_state == sac_pkg::ST_READ),
        .i_rd_set   (r_set),
        .i_wr_en    (row_we),
        .i_wr_set   (r_set),
        .i_wr_tags  (wr_tags),
        .i_wr_vld   (wr_vld),
        .i_wr_dirty (wr_dirty),
        .i_wr_age   (wr_age),
        .o_rd_tags  (rd_tags),
        .o_rd_vld   (rd_vld),
        .o_rd_dirty (rd_dirty),
        .o_rd_age   (rd_age)
    );

    sac_scan #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .WAY_W      (WAY_W),
        .AGE_W      (AGE_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == sac_pkg::ST_READ),
        .i_run      (r_state == sac_pkg::ST_SCAN),
        .i_last_way (last_way),
        .i_tag      (r_tag),
        .i_tags     (rd_tags),
        .i_vld      (rd_vld),
        .i_age      (rd_age),
        .o_done     (scan_done),
        .o_res      (scan_res)
    );

    // Row update: LRU ageing, victim fill and dirty marking.
    logic [WAY_W-1:0] hw, victim;
    logic [AGE_W-1:0] hage;
    logic             alloc;
    logic             evd;
    logic             mark_dirty;

    assign hw         = WAY_W'(scan_res.hit_way);
    assign victim     = scan_res.has_inv ? WAY_W'(scan_res.inv_way)
                                         : WAY_W'(scan_res.old_way);
    assign hage       = rd_age[hw];
    assign alloc      = !scan_res.hit && (!r_store || r_wa);
    assign evd        = alloc && !scan_res.has_inv && rd_dirty[victim];
    assign mark_dirty = r_store && !r_wt;
    assign row_we     = upd_go && (scan_res.hit || alloc);

    always_comb begin
        wr_tags  = rd_tags;
        wr_vld   = rd_vld;
        wr_dirty = rd_dirty;
        wr_age   = rd_age;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(ways) && rd_vld[w] && rd_age[w] < AGE_MAX) begin
                if (scan_res.hit) begin
                    if (rd_age[w] < hage) wr_age[w] = rd_age[w] + 1'b1;
                end else if (WAY_W'(w) != victim) begin
                    wr_age[w] = rd_age[w] + 1'b1;
                end
            end
        end
        if (scan_res.hit) begin
            wr_age[hw] = '0;
            if (mark_dirty) wr_dirty[hw] = 1'b1;
        end else begin
            wr_tags[victim]  = r_tag;
            wr_vld[victim]   = 1'b1;
            wr_dirty[victim] = mark_dirty;
            wr_age[victim]   = '0;
        end
    end

    // Cost of this access
    logic [15:0] xfer;
    logic [15:0] cost;

    assign xfer = 16'(16'(sac_pkg::MISS_BYTE_CYC) << ob);

    always_comb begin
        if (scan_res.hit) begin
            cost = (r_store && r_wt) ? 16'(1 + sac_pkg::WT_CYC) : 16'd1;
        end else if (!r_store) begin
            cost = evd ? 16'(xfer + xfer) : xfer;
        end else if (r_wa) begin
            cost = 16'((evd ? 16'(xfer + xfer) : xfer) + 16'd1
                       + (r_wt ? 16'(sac_pkg::WT_CYC) : 16'd0));
        end else begin
            cost = 16'(sac_pkg::WT_CYC);
        end
    end

    // Saturating running totals
    logic [31:0] r_loads, r_stores, r_ld_hit, r_ld_miss, r_st_hit, r_st_miss;
    logic [31:0] n_loads, n_stores, n_ld_hit, n_ld_miss, n_st_hit, n_st_miss;
    logic [63:0] r_total, n_total;
    logic [64:0] total_sum;

    function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
        sat_inc = (en && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
    endfunction

    assign total_sum = {1'b0, r_total} + {49'd0, cost};

    always_comb begin
        n_loads   = sat_inc(r_loads,   !r_store);
        n_stores  = sat_inc(r_stores,  r_store);
        n_ld_hit  = sat_inc(r_ld_hit,  !r_store && scan_res.hit);
        n_ld_miss = sat_inc(r_ld_miss, !r_store && !scan_res.hit);
        n_st_hit  = sat_inc(r_st_hit,  r_store && scan_res.hit);
        n_st_miss = sat_inc(r_st_miss, r_store && !scan_res.hit);
        n_total   = total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loads   <= '0;
            r_stores  <= '0;
            r_ld_hit  <= '0;
            r_ld_miss <= '0;
            r_st_hit  <= '0;
            r_st_miss <= '0;
            r_total   <= '0;
        end else if (upd_go) begin
            r_loads   <= n_loads;
            r_stores  <= n_stores;
            r_ld_hit  <= n_ld_hit;
            r_ld_miss <= n_ld_miss;
            r_st_hit  <= n_st_hit;
            r_st_miss <= n_st_miss;
            r_total   <= n_total;
        end
    end

    // Result register
    logic                            r_m_valid;
    logic [sac_pkg::OUT_TDATA_W-1:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (upd_go) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_m_data <= {6'd0, n_total, n_st_miss, n_st_hit, n_ld_miss, n_ld_hit,
                         n_stores, n_loads, cost, evd, scan_res.hit};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== src/sac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks for the cache timing block, bound to the top level.
// ----------------------------------------------------------------------------
module sac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // An accepted access keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted transaction");

    // A stalled result holds still.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
        else $error("hit reported with a dirty eviction");

    // A hit reports an access cost of 1, or 1 plus the memory write cost when writing through.
    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[17:2] == 16'd1 || m_axis_tdata[17:2] == 16'd101))
        else $error("hit with unexpected access cycles");

endmodule

bind set_assoc_cache_lru_timing_top sac_checker u_sac_checker (.*);
